>>> rtl/dlsq_pkg.sv
// dlsq_pkg: shared types and codes for the delta-list sleep queue
// used by dlsq_cell, delta_list_sleep_queue and dlsq_checker; no dependencies
`default_nettype none

package dlsq_pkg;

    localparam int DELTA_W     = 16;
    localparam int THREAD_W    = 8;
    localparam int MAX_RESULTS = 16;
    localparam int K_W         = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] FN_ADD  = 2'd0;
    localparam logic [1:0] FN_TICK = 2'd1;
    localparam logic [1:0] FN_WAKE = 2'd2;
    localparam logic [1:0] FN_TAKE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // what a cell shows to its neighbors and to the sequencer
    typedef struct packed {
        logic                valid;
        logic                tok;
        logic [DELTA_W-1:0]  delta;
        logic [THREAD_W-1:0] thread;
    } t_cell_view;

    // per-cell control from the sequencer
    typedef struct packed {
        logic start;   // begin an insertion walk
        logic seed;    // this cell takes the walk token at start
        logic adv;     // token moves one cell right
        logic ins;     // insert at the token cell, shift the tail right
        logic pop;     // shift the whole row left by one
        logic fold;    // add own delta into the incoming delta on pop
        logic dec;     // count own delta down by one
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/dlsq_cell.sv
// dlsq_cell: one queue slot holding thread id, delta ticks and occupancy
// depends on dlsq_pkg; instantiated in a row by delta_list_sleep_queue
`default_nettype none

module dlsq_cell
    import dlsq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctl           i_ctl,
    input  wire t_cell_view          i_left,
    input  wire t_cell_view          i_right,
    input  wire logic [DELTA_W-1:0]  i_rem,
    input  wire logic [DELTA_W-1:0]  i_adj_delta,
    input  wire logic [THREAD_W-1:0] i_new_thread,
    output t_cell_view               o_view
);

    logic                r_valid;
    logic                r_tok;
    logic                r_after;
    logic [DELTA_W-1:0]  r_delta;
    logic [THREAD_W-1:0] r_thread;

    logic [DELTA_W:0]    w_sum;

    assign w_sum = {1'b0, i_right.delta} + {1'b0, r_delta};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
            r_after <= 1'b0;
        end else if (i_ctl.start) begin
            r_tok   <= i_ctl.seed;
            r_after <= 1'b1;
        end else if (i_ctl.adv) begin
            r_tok   <= i_left.tok;
            r_after <= r_after & ~r_tok;
        end else if (i_ctl.ins) begin
            r_tok   <= 1'b0;
            r_after <= 1'b0;
            if (r_tok) begin
                r_valid  <= 1'b1;
                r_delta  <= i_rem;
                r_thread <= i_new_thread;
            end else if (r_after) begin
                r_valid  <= i_left.valid;
                r_thread <= i_left.thread;
                // entry right behind the new one gives up the inserted ticks
                r_delta  <= i_left.tok ? i_adj_delta : i_left.delta;
            end
        end else if (i_ctl.pop) begin
            r_valid  <= i_right.valid;
            r_thread <= i_right.thread;
            if (i_ctl.fold) begin
                r_delta <= w_sum[DELTA_W] ? {DELTA_W{1'b1}} : w_sum[DELTA_W-1:0];
            end else begin
                r_delta <= i_right.delta;
            end
        end else if (i_ctl.dec) begin
            if (r_valid && r_delta != '0) begin
                r_delta <= r_delta - 1'b1;
            end
        end
    end

    assign o_view.valid  = r_valid;
    assign o_view.tok    = r_tok;
    assign o_view.delta  = r_delta;
    assign o_view.thread = r_thread;

endmodule

`default_nettype wire

>>> rtl/delta_list_sleep_queue.sv
// delta_list_sleep_queue: top level, sequencer plus a row of dlsq_cell slots
// depends on dlsq_pkg and dlsq_cell
`default_nettype none

// Sleep queue of thread ids kept as a delta list in a row of CAPACITY cells;
// each cell holds a thread id, its ticks beyond the previous cell, and an
// occupied bit. One transaction is taken at a time and o_stall stays high
// until its last result is loaded into the output register. An add walks a
// token down the row one cell per cycle to the insertion position (0 to
// CAPACITY-1), then posts the status. A tick or wake-all releases its
// threads in turn (at most 16 per transaction, at least one result), since
// each release shifts the whole row left by one. Every result waits while
// the output is stalled.

module delta_list_sleep_queue
    import dlsq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_func,
    input  wire logic [THREAD_W-1:0] i_req_thread,
    input  wire logic [DELTA_W-1:0]  i_sleep_ticks,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [THREAD_W-1:0]      o_out_thread,
    output logic                     o_thread_valid,
    output logic [1:0]               o_status,
    output logic                     o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REPLY,
        S_BURST,
        S_TAKE
    } t_state;

    t_state              r_state, n_state;
    logic [DELTA_W-1:0]  r_rem, n_rem;
    logic [THREAD_W-1:0] r_new_thread, n_new_thread;
    logic                r_wake, n_wake;
    logic [K_W-1:0]      r_k, n_k;
    logic [1:0]          r_reply_st, n_reply_st;

    logic                r_o_valid, n_o_valid;
    logic [THREAD_W-1:0] r_out_thread, n_out_thread;
    logic                r_thread_valid, n_thread_valid;
    logic [1:0]          r_status, n_status;
    logic                r_last, n_last;

    t_cell_view          w_view [0:CAPACITY];
    t_cell_ctl           w_ctl  [0:CAPACITY-1];

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_full;
    logic                w_sel_valid;
    logic [DELTA_W-1:0]  w_sel_delta;
    logic [DELTA_W-1:0]  w_adj_delta;
    logic                w_qual_head;
    logic                w_qual_next;
    logic                c_start, c_adv, c_ins, c_pop, c_fold, c_dec;

    assign w_in_acc    = i_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_full      = w_view[CAPACITY-1].valid;
    assign w_adj_delta = w_sel_delta - r_rem;

    // the token is one-hot, so an and-or picks the cell under it
    always_comb begin
        w_sel_valid = 1'b0;
        w_sel_delta = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel_valid = w_sel_valid | (w_view[i].tok & w_view[i].valid);
            w_sel_delta = w_sel_delta | (w_view[i].tok ? w_view[i].delta : '0);
        end
    end

    assign w_qual_head = w_view[0].valid && (r_wake || w_view[0].delta == '0)
                         && (r_k < K_W'(MAX_RESULTS));
    assign w_qual_next = w_view[1].valid && (r_wake || w_view[1].delta == '0)
                         && (K_W'(r_k + 1'b1) < K_W'(MAX_RESULTS));

    always_comb begin
        n_state        = r_state;
        n_rem          = r_rem;
        n_new_thread   = r_new_thread;
        n_wake         = r_wake;
        n_k            = r_k;
        n_reply_st     = r_reply_st;
        n_o_valid      = r_o_valid && i_stall;
        n_out_thread   = r_out_thread;
        n_thread_valid = r_thread_valid;
        n_status       = r_status;
        n_last         = r_last;
        c_start        = 1'b0;
        c_adv          = 1'b0;
        c_ins          = 1'b0;
        c_pop          = 1'b0;
        c_fold         = 1'b0;
        c_dec          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_k  = '0;
                    case (i_func)
                        FN_ADD: begin
                            if (w_full) begin
                                n_reply_st = ST_FULL;
                                n_state    = S_REPLY;
                            end else begin
                                c_start      = 1'b1;
                                n_rem        = (i_sleep_ticks == '0) ? DELTA_W'(1)
                                                                     : i_sleep_ticks;
                                n_new_thread = i_req_thread;
                                n_state      = S_SCAN;
                            end
                        end
                        FN_TICK: begin
                            c_dec   = 1'b1;
                            n_wake  = 1'b0;
                            n_state = S_BURST;
                        end
                        FN_WAKE: begin
                            n_wake  = 1'b1;
                            n_state = S_BURST;
                        end
                        FN_TAKE: begin
                            n_state = S_TAKE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_sel_valid && r_rem >= w_sel_delta) begin
                    c_adv = 1'b1;
                    n_rem = r_rem - w_sel_delta;
                end else begin
                    c_ins      = 1'b1;
                    n_reply_st = ST_OK;
                    n_state    = S_REPLY;
                end
            end
            S_REPLY: begin
                if (w_out_free) begin
                    n_o_valid      = 1'b1;
                    n_out_thread   = '0;
                    n_thread_valid = 1'b0;
                    n_status       = r_reply_st;
                    n_last         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_BURST: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_status  = ST_OK;
                    if (w_qual_head) begin
                        c_pop          = 1'b1;
                        n_k            = K_W'(r_k + 1'b1);
                        n_out_thread   = w_view[0].thread;
                        n_thread_valid = 1'b1;
                        n_last         = !w_qual_next;
                        if (!w_qual_next) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        // nothing due on this transaction
                        n_out_thread   = '0;
                        n_thread_valid = 1'b0;
                        n_last         = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            S_TAKE: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                    if (w_view[0].valid) begin
                        c_pop          = 1'b1;
                        c_fold         = 1'b1;
                        n_out_thread   = w_view[0].thread;
                        n_thread_valid = 1'b1;
                        n_status       = ST_OK;
                    end else begin
                        n_out_thread   = '0;
                        n_thread_valid = 1'b0;
                        n_status       = ST_EMPTY;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_wake    <= 1'b0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_wake    <= n_wake;
            r_k       <= n_k;
        end
        r_rem          <= n_rem;
        r_new_thread   <= n_new_thread;
        r_reply_st     <= n_reply_st;
        r_out_thread   <= n_out_thread;
        r_thread_valid <= n_thread_valid;
        r_status       <= n_status;
        r_last         <= n_last;
    end

    assign w_view[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_view w_left;

        assign w_left = (g == 0) ? t_cell_view'('0) : w_view[(g == 0) ? 0 : g - 1];

        assign w_ctl[g].start = c_start;
        assign w_ctl[g].seed  = (g == 0);
        assign w_ctl[g].adv   = c_adv;
        assign w_ctl[g].ins   = c_ins;
        assign w_ctl[g].pop   = c_pop;
        assign w_ctl[g].fold  = c_fold && (g == 0);
        assign w_ctl[g].dec   = c_dec && (g == 0);

        dlsq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_left       (w_left),
            .i_right      (w_view[g + 1]),
            .i_rem        (r_rem),
            .i_adj_delta  (w_adj_delta),
            .i_new_thread (r_new_thread),
            .o_view       (w_view[g])
        );
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_out_thread   = r_out_thread;
    assign o_thread_valid = r_thread_valid;
    assign o_status       = r_status;
    assign o_last         = r_last;

endmodule

`default_nettype wire

>>> rtl/dlsq_checker.sv
// dlsq_checker: port-level assertions for delta_list_sleep_queue
// depends on dlsq_pkg; bound to the top level at the end of this file
`default_nettype none

module dlsq_checker
    import dlsq_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [THREAD_W-1:0] o_out_thread,
    input wire logic                o_thread_valid,
    input wire logic [1:0]          o_status,
    input wire logic                o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_thread)
            && $stable(o_thread_valid) && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after a transaction was taken");

    a_thread_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_thread_valid |-> o_status == ST_OK)
        else $error("thread result with error status");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && !o_thread_valid)
        else $error("error status not a lone final result");

    a_no_thread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_thread_valid |-> o_out_thread == '0 && o_last)
        else $error("empty result carries a thread id or is not final");

endmodule

bind delta_list_sleep_queue dlsq_checker u_dlsq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_thread   (o_out_thread),
    .o_thread_valid (o_thread_valid),
    .o_status       (o_status),
    .o_last         (o_last)
);

`default_nettype wire

>>> dv/tb.sv
// tb: self-checking testbench for delta_list_sleep_queue
// depends on dlsq_pkg and the delta_list_sleep_queue rtl; predicts every result in-line

module tb;
    import dlsq_pkg::*;

    localparam int CAP = 16;

    typedef struct packed {
        logic [THREAD_W-1:0] thr;
        logic                tv;
        logic [1:0]          st;
        logic                last;
    } t_wake_res;

    typedef struct packed {
        logic [1:0]          fn;
        logic [THREAD_W-1:0] thr;
        logic [DELTA_W-1:0]  ticks;
        logic                typed;
        logic [1:0]          st;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_func;
    logic [THREAD_W-1:0] i_req_thread;
    logic [DELTA_W-1:0]  i_sleep_ticks;
    logic                o_valid;
    logic                i_stall;
    logic [THREAD_W-1:0] o_out_thread;
    logic                o_thread_valid;
    logic [1:0]          o_status;
    logic                o_last;

    // predictor copy of the queue
    logic [DELTA_W-1:0]  sq_delta [CAP];
    logic [THREAD_W-1:0] sq_thread [CAP];
    int                  sq_count;

    t_wake_res step_out [$];
    t_wake_res due_results [$];
    t_plan_row plan [$];
    int        n_errors = 0;
    int        rcv_n = 0;

    delta_list_sleep_queue #(.CAPACITY(CAP)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_req_thread   (i_req_thread),
        .i_sleep_ticks  (i_sleep_ticks),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_thread   (o_out_thread),
        .o_thread_valid (o_thread_valid),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic push_result(input logic [THREAD_W-1:0] thr, input logic tv,
                               input logic [1:0] st);
        t_wake_res r;
        r.thr  = thr;
        r.tv   = tv;
        r.st   = st;
        r.last = 1'b0;
        step_out.push_back(r);
    endtask

    function automatic logic [THREAD_W-1:0] pop_first();
        logic [THREAD_W-1:0] t;
        t = sq_thread[0];
        for (int i = 1; i < sq_count; i++) begin
            sq_delta[i-1]  = sq_delta[i];
            sq_thread[i-1] = sq_thread[i];
        end
        sq_count--;
        sq_delta[sq_count] = '0;
        return t;
    endfunction

    // applies one transaction to the predictor and leaves its results in step_out
    task automatic sleep_queue_apply(input logic [1:0] fn, input logic [THREAD_W-1:0] thr,
                                     input logic [DELTA_W-1:0] ticks);
        int        rem;
        int        pos;
        int        sum;
        t_wake_res r;
        step_out.delete();
        case (fn)
            FN_ADD: begin
                if (sq_count >= CAP) begin
                    push_result('0, 1'b0, ST_FULL);
                end else begin
                    rem = (ticks == 0) ? 1 : int'(ticks);
                    pos = 0;
                    while (pos < sq_count && rem >= int'(sq_delta[pos])) begin
                        rem -= int'(sq_delta[pos]);
                        pos++;
                    end
                    if (pos < sq_count) sq_delta[pos] = sq_delta[pos] - rem[DELTA_W-1:0];
                    for (int i = sq_count; i > pos; i--) begin
                        sq_delta[i]  = sq_delta[i-1];
                        sq_thread[i] = sq_thread[i-1];
                    end
                    sq_delta[pos]  = rem[DELTA_W-1:0];
                    sq_thread[pos] = thr;
                    sq_count++;
                    push_result('0, 1'b0, ST_OK);
                end
            end
            FN_TICK: begin
                if (sq_count > 0) begin
                    if (sq_delta[0] != 0) sq_delta[0] = sq_delta[0] - 1'b1;
                    // due entries past the burst cap stay at the head with zero delta
                    while (sq_count > 0 && sq_delta[0] == 0 && step_out.size() < MAX_RESULTS)
                        push_result(pop_first(), 1'b1, ST_OK);
                end
                if (step_out.size() == 0) push_result('0, 1'b0, ST_OK);
            end
            FN_WAKE: begin
                while (sq_count > 0 && step_out.size() < MAX_RESULTS)
                    push_result(pop_first(), 1'b1, ST_OK);
                if (step_out.size() == 0) push_result('0, 1'b0, ST_OK);
            end
            default: begin
                if (sq_count == 0) begin
                    push_result('0, 1'b0, ST_EMPTY);
                end else begin
                    if (sq_count > 1) begin
                        sum = int'(sq_delta[1]) + int'(sq_delta[0]);
                        sq_delta[1] = (sum > 65535) ? 16'hFFFF : sum[DELTA_W-1:0];
                    end
                    push_result(pop_first(), 1'b1, ST_OK);
                end
            end
        endcase
        r = step_out.pop_back();
        r.last = 1'b1;
        step_out.push_back(r);
    endtask

    task automatic offer(input logic [1:0] fn, input logic [THREAD_W-1:0] thr,
                         input logic [DELTA_W-1:0] ticks, input logic typed,
                         input logic [1:0] st, input bit calm);
        int        gap;
        t_wake_res r;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= fn;
        i_req_thread  <= thr;
        i_sleep_ticks <= ticks;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sleep_queue_apply(fn, thr, ticks);
        if (typed) begin
            r.thr  = '0;
            r.tv   = 1'b0;
            r.st   = st;
            r.last = 1'b1;
            due_results.push_back(r);
        end else begin
            foreach (step_out[j]) due_results.push_back(step_out[j]);
        end
    endtask

    task automatic plan_row(input logic [1:0] fn, input logic [THREAD_W-1:0] thr,
                            input logic [DELTA_W-1:0] ticks, input logic typed,
                            input logic [1:0] st);
        t_plan_row p;
        p.fn    = fn;
        p.thr   = thr;
        p.ticks = ticks;
        p.typed = typed;
        p.st    = st;
        plan.push_back(p);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_wake_res want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (due_results.size() == 0) begin
                note_mismatch("result with nothing pending");
            end else begin
                want = due_results.pop_front();
                if (o_out_thread !== want.thr)
                    note_mismatch($sformatf("out_thread %h, want %h", o_out_thread, want.thr));
                if (o_thread_valid !== want.tv)
                    note_mismatch($sformatf("thread_valid %b, want %b",
                                            o_thread_valid, want.tv));
                if (o_status !== want.st)
                    note_mismatch($sformatf("status %0d, want %0d", o_status, want.st));
                if (o_last !== want.last)
                    note_mismatch($sformatf("last %b, want %b", o_last, want.last));
            end
        end
    end

    // receiver: random stall per result, calm stretches, one long hold-off
    initial begin
        int gap;
        bit long_done;
        long_done = 1'b0;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rcv_n == 120 && !long_done) begin
                gap = 300;
                long_done = 1'b1;
            end else if ((rcv_n / 30) % 4 == 1) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 4);
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            rcv_n++;
        end
    end

    initial begin
        int         r;
        int         s;
        int         mode;
        logic [1:0] fn;
        logic [15:0] ticks;

        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_func        <= FN_ADD;
        i_req_thread  <= '0;
        i_sleep_ticks <= '0;
        sq_count = 0;
        for (int i = 0; i < CAP; i++) begin
            sq_delta[i]  = '0;
            sq_thread[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty cases, zero sleep, extremes, equal wake times, full, take, wake
        plan_row(FN_TAKE, 8'h00, 16'h0000, 1'b1, ST_EMPTY);
        plan_row(FN_TICK, 8'h00, 16'h0000, 1'b1, ST_OK);
        plan_row(FN_WAKE, 8'h00, 16'h0000, 1'b1, ST_OK);
        plan_row(FN_ADD,  8'hFF, 16'h0000, 1'b1, ST_OK);
        plan_row(FN_TICK, 8'h00, 16'h0000, 1'b0, ST_OK);
        plan_row(FN_ADD,  8'h00, 16'hFFFF, 1'b1, ST_OK);
        plan_row(FN_ADD,  8'hA5, 16'd5,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'h5A, 16'd5,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'h01, 16'd3,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'h80, 16'hFFFF, 1'b0, ST_OK);
        plan_row(FN_ADD,  8'h7E, 16'd1,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'h11, 16'd2,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'h22, 16'd5,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'h33, 16'd0,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'h44, 16'd9,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'h55, 16'd100,  1'b0, ST_OK);
        plan_row(FN_ADD,  8'h66, 16'd4,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'h77, 16'd5,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'h88, 16'hFFFE, 1'b0, ST_OK);
        plan_row(FN_ADD,  8'h99, 16'd1,    1'b0, ST_OK);
        plan_row(FN_ADD,  8'hAA, 16'd300,  1'b0, ST_OK);
        plan_row(FN_ADD,  8'hC3, 16'd7,    1'b1, ST_FULL);
        plan_row(FN_TAKE, 8'h00, 16'h0000, 1'b0, ST_OK);
        plan_row(FN_TICK, 8'h00, 16'h0000, 1'b0, ST_OK);
        plan_row(FN_WAKE, 8'h00, 16'h0000, 1'b0, ST_OK);

        foreach (plan[k])
            offer(plan[k].fn, plan[k].thr, plan[k].ticks, plan[k].typed, plan[k].st,
                  (k % 7) < 3);

        // random: phases lean toward filling, mixing, or draining the queue
        for (int n = 0; n < 370; n++) begin
            mode = (n / 50) % 3;
            r = $urandom_range(0, 99);
            if (mode == 0)
                fn = (r < 70) ? FN_ADD : (r < 85) ? FN_TICK : (r < 95) ? FN_TAKE : FN_WAKE;
            else if (mode == 1)
                fn = (r < 45) ? FN_ADD : (r < 75) ? FN_TICK : (r < 93) ? FN_TAKE : FN_WAKE;
            else
                fn = (r < 25) ? FN_ADD : (r < 80) ? FN_TICK : (r < 95) ? FN_TAKE : FN_WAKE;
            s = $urandom_range(0, 99);
            if (s < 10)
                ticks = 16'h0000;
            else if (s < 15)
                ticks = 16'hFFFF;
            else if (s < 25)
                ticks = 16'($urandom_range(0, 65535));
            else
                ticks = 16'($urandom_range(1, 12));
            offer(fn, 8'($urandom_range(0, 255)), ticks, 1'b0, ST_OK, (n / 30) % 4 == 3);
        end
        i_valid <= 1'b0;

        for (int w = 0; w < 5000 && due_results.size() != 0; w++) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (due_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", due_results.size()));

        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
